>>> rtl/doolittle_lu_decomposer_macros.svh
`ifndef DOOLITTLE_LU_DECOMPOSER_MACROS_SVH
`define DOOLITTLE_LU_DECOMPOSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define DLU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DLU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dlu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dlu_pkg;

  localparam int MAX_DIM = 8;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * DIM_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int DATA_W  = 48;
  localparam int SIZE_W  = 4;
  localparam int DIV_STEPS = 72;

  localparam logic signed [DATA_W-1:0] ONE_Q24 = 48'sd16777216;
  localparam logic signed [DATA_W-1:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [DATA_W-1:0] NEG_MIN = 48'sh8000_0000_0000;

  typedef enum logic [3:0] {
    S_LOAD,
    S_ACC_RD,
    S_ACC_WT,
    S_A_RD,
    S_B_RD,
    S_B_WT,
    S_MUL,
    S_RND,
    S_SUB,
    S_FIN,
    S_DIV,
    S_DIV_END,
    S_OUT_RD,
    S_OUT
  } state_t;

  // magnitude of a 48-bit signed value, -2^47 gives 2^47
  function automatic logic [DATA_W-1:0] mag48(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = v[DATA_W-1] ? (~v + 48'd1) : v;
    return r;
  endfunction

  // apply sign to a magnitude and saturate to 48 bits
  function automatic logic signed [DATA_W-1:0] sat_signed(input logic [49:0] m,
                                                         input logic neg,
                                                         input logic big);
    logic signed [DATA_W-1:0] r;
    if (neg) begin
      if (big || m >= 50'h0_8000_0000_0000) r = NEG_MIN;
      else r = -$signed(m[DATA_W-1:0]);
    end else begin
      if (big || m > 50'h0_7FFF_FFFF_FFFF) r = POS_MAX;
      else r = $signed(m[DATA_W-1:0]);
    end
    return r;
  endfunction

  // subtraction that saturates to 48 bits
  function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    logic [DATA_W:0] d;
    logic signed [DATA_W-1:0] r;
    d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (!d[DATA_W] && d[DATA_W-1]) r = POS_MAX;
    else if (d[DATA_W] && !d[DATA_W-1]) r = NEG_MIN;
    else r = $signed(d[DATA_W-1:0]);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/doolittle_lu_decomposer.sv
// Doolittle LU decomposer
// s_tdata carries one signed 16-bit matrix element per transfer, row-major,
// for an n x n matrix where n comes from cfg_wdata (0 acts as 1, above 8 as 8).
// cfg_we writes the size and restarts the load; write only while idle.
// the transfer that completes the matrix starts an in-place decomposition
// in a 64 x 48 store; s_tready is low from then until the last result leaves.
// results come out as n*n transfers in row-major order on the m_ side,
// each read in S_OUT_RD and then offered in S_OUT; a low m_tready simply holds
// the current result. m_tlast marks the final entry, m_tuser the singular flag.
// loading accepts one element per cycle. decomposition time is set by the
// shared multiplier (four 24x24 partial products per multiply-accumulate)
// and the bit-serial divider. reset clears the load position and flag and
// sets the size to 8; the store needs no clearing since only freshly loaded
// entries are read.
`timescale 1ns / 1ps
`default_nettype none
`include "doolittle_lu_decomposer_macros.svh"

module doolittle_lu_decomposer (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [15:0]  s_tdata,   // element_value
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [103:0] m_tdata,   // row_index, col_index, lower_value, upper_value, pad
  output logic         m_tuser,   // singular
  output logic         m_tlast,
  input  wire          cfg_we,
  input  wire  [3:0]   cfg_wdata  // matrix_size
);

  localparam int DW = dlu_pkg::DATA_W;
  localparam int IW = dlu_pkg::DIM_W;
  localparam int AW = dlu_pkg::ADDR_W;

  dlu_pkg::state_t state, state_next;

  logic [dlu_pkg::SIZE_W-1:0] size_n;
  logic [IW-1:0] last_idx;
  logic [IW-1:0] ld_row, ld_col;
  logic [IW-1:0] i_cnt, j_cnt, k_cnt;
  logic          phase_l;
  logic [IW-1:0] oi, oj;
  logic          sing;

  logic signed [DW-1:0] acc, piv, mres;
  logic [DW-1:0] amag, bmag;
  logic          mneg;
  logic [95:0]   prod;
  logic [1:0]    mcnt;

  logic [71:0]   dsh;
  logic [DW-1:0] rem, dmd;
  logic [49:0]   quo;
  logic          dbig, dneg;
  logic [6:0]    dcnt;

  logic signed [DW-1:0] mem [dlu_pkg::DEPTH];
  logic signed [DW-1:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic signed [DW-1:0] wdata;
  logic          we;

  logic [AW-1:0] tgt_addr, a_addr, b_addr;
  logic          in_xfer, out_xfer, ld_done, adv_last;
  logic [47:0]   pp;
  logic [95:0]   pp_sh, rnd;
  logic [DW:0]   r2;
  logic          r2_ge;
  logic [49:0]   q_step;
  logic signed [DW-1:0] div_res;
  logic signed [DW-1:0] lower_v, upper_v;

  assign last_idx = IW'(size_n - 4'd1);
  assign tgt_addr = phase_l ? {j_cnt, i_cnt} : {i_cnt, j_cnt};
  assign a_addr   = phase_l ? {j_cnt, k_cnt} : {i_cnt, k_cnt};
  assign b_addr   = phase_l ? {k_cnt, i_cnt} : {k_cnt, j_cnt};
  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign ld_done  = (ld_row == last_idx) && (ld_col == last_idx);
  assign adv_last = !phase_l && (j_cnt == last_idx) && (i_cnt == last_idx);

  // memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // partial product of the split multiply
  always_comb begin
    pp = (mcnt[1] ? amag[47:24] : amag[23:0]) * (mcnt[0] ? bmag[47:24] : bmag[23:0]);
    unique case (mcnt)
      2'd0:    pp_sh = {48'd0, pp};
      2'd1,
      2'd2:    pp_sh = {24'd0, pp, 24'd0};
      default: pp_sh = {pp, 48'd0};
    endcase
    rnd = prod + 96'd8388608;
  end

  // divider step and final rounding
  always_comb begin
    r2     = {rem, dsh[71]};
    r2_ge  = r2 >= {1'b0, dmd};
    q_step = {quo[48:0], r2_ge};
    div_res = dlu_pkg::sat_signed(
      (!dbig && ({rem, 1'b0} >= {1'b0, dmd})) ? quo + 50'd1 : quo, dneg, dbig);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dlu_pkg::S_LOAD:   if (in_xfer && ld_done) state_next = dlu_pkg::S_ACC_RD;
      dlu_pkg::S_ACC_RD: state_next = dlu_pkg::S_ACC_WT;
      dlu_pkg::S_ACC_WT: state_next = (i_cnt == '0) ? dlu_pkg::S_FIN : dlu_pkg::S_A_RD;
      dlu_pkg::S_A_RD:   state_next = dlu_pkg::S_B_RD;
      dlu_pkg::S_B_RD:   state_next = dlu_pkg::S_B_WT;
      dlu_pkg::S_B_WT:   state_next = dlu_pkg::S_MUL;
      dlu_pkg::S_MUL:    if (mcnt == 2'd3) state_next = dlu_pkg::S_RND;
      dlu_pkg::S_RND:    state_next = dlu_pkg::S_SUB;
      dlu_pkg::S_SUB:    state_next = (k_cnt + 3'd1 == i_cnt) ? dlu_pkg::S_FIN
                                                              : dlu_pkg::S_A_RD;
      dlu_pkg::S_FIN: begin
        if (phase_l && piv != '0) state_next = dlu_pkg::S_DIV;
        else if (adv_last) state_next = dlu_pkg::S_OUT_RD;
        else state_next = dlu_pkg::S_ACC_RD;
      end
      dlu_pkg::S_DIV:     if (dcnt == 7'(dlu_pkg::DIV_STEPS - 1)) state_next = dlu_pkg::S_DIV_END;
      dlu_pkg::S_DIV_END: state_next = dlu_pkg::S_ACC_RD;
      dlu_pkg::S_OUT_RD:  state_next = dlu_pkg::S_OUT;
      dlu_pkg::S_OUT: begin
        if (m_tready) begin
          if (oi == last_idx && oj == last_idx) state_next = dlu_pkg::S_LOAD;
          else state_next = dlu_pkg::S_OUT_RD;
        end
      end
      default: state_next = dlu_pkg::S_LOAD;
    endcase
  end

  // outputs and memory control
  always_comb begin
    s_tready = (state == dlu_pkg::S_LOAD);
    m_tvalid = (state == dlu_pkg::S_OUT);
    we    = 1'b0;
    waddr = tgt_addr;
    wdata = acc;
    raddr = tgt_addr;
    unique case (state)
      dlu_pkg::S_LOAD: begin
        we    = in_xfer;
        waddr = {ld_row, ld_col};
        wdata = {{8{s_tdata[15]}}, s_tdata, 24'd0};
      end
      dlu_pkg::S_A_RD: raddr = a_addr;
      dlu_pkg::S_B_RD: raddr = b_addr;
      dlu_pkg::S_FIN: begin
        we    = !(phase_l && piv != '0);
        wdata = phase_l ? '0 : acc;
      end
      dlu_pkg::S_DIV_END: begin
        we    = 1'b1;
        wdata = div_res;
      end
      dlu_pkg::S_OUT_RD,
      dlu_pkg::S_OUT: raddr = {oi, oj};
      default: ;
    endcase

    lower_v = (oi > oj) ? rdata : ((oi == oj) ? dlu_pkg::ONE_Q24 : '0);
    upper_v = (oi <= oj) ? rdata : '0;
    m_tdata = {2'b00, upper_v, lower_v, oj, oi};
    m_tuser = sing;
    m_tlast = (oi == last_idx) && (oj == last_idx);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= dlu_pkg::S_LOAD;
      size_n <= 4'd8;
      ld_row <= '0;
      ld_col <= '0;
      sing   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        size_n <= (cfg_wdata == 4'd0) ? 4'd1 :
                  ((cfg_wdata > 4'(dlu_pkg::MAX_DIM)) ? 4'(dlu_pkg::MAX_DIM) : cfg_wdata);
        ld_row <= '0;
        ld_col <= '0;
        sing   <= 1'b0;
      end else if (in_xfer) begin
        if (ld_col == last_idx) begin
          ld_col <= '0;
          ld_row <= ld_done ? '0 : ld_row + 3'd1;
        end else begin
          ld_col <= ld_col + 3'd1;
        end
        if (ld_done) sing <= 1'b0;
      end else if (state == dlu_pkg::S_FIN && !phase_l && i_cnt == j_cnt && acc == '0) begin
        sing <= 1'b1;
      end
    end
  end

  // loop counters and datapath
  always_ff @(posedge clk) begin
    unique case (state)
      dlu_pkg::S_LOAD: begin
        i_cnt   <= '0;
        j_cnt   <= '0;
        k_cnt   <= '0;
        phase_l <= 1'b0;
        oi      <= '0;
        oj      <= '0;
      end
      dlu_pkg::S_ACC_WT: begin
        acc   <= rdata;
        k_cnt <= '0;
      end
      dlu_pkg::S_B_RD: begin
        amag <= dlu_pkg::mag48(rdata);
        mneg <= rdata[DW-1];
      end
      dlu_pkg::S_B_WT: begin
        bmag <= dlu_pkg::mag48(rdata);
        mneg <= mneg ^ rdata[DW-1];
        prod <= '0;
        mcnt <= '0;
      end
      dlu_pkg::S_MUL: begin
        prod <= prod + pp_sh;
        mcnt <= mcnt + 2'd1;
      end
      dlu_pkg::S_RND: mres <= dlu_pkg::sat_signed({2'b00, rnd[71:24]}, mneg, |rnd[95:72]);
      dlu_pkg::S_SUB: begin
        acc   <= dlu_pkg::sat_sub(acc, mres);
        k_cnt <= k_cnt + 3'd1;
      end
      dlu_pkg::S_FIN: begin
        if (!phase_l && i_cnt == j_cnt) piv <= acc;
        if (phase_l && piv != '0) begin
          dsh  <= {dlu_pkg::mag48(acc), 24'd0};
          dmd  <= dlu_pkg::mag48(piv);
          dneg <= acc[DW-1] ^ piv[DW-1];
          rem  <= '0;
          quo  <= '0;
          dbig <= 1'b0;
          dcnt <= '0;
        end else if (!phase_l) begin
          if (j_cnt == last_idx) begin
            if (!adv_last) begin
              phase_l <= 1'b1;
              j_cnt   <= i_cnt + 3'd1;
            end
          end else begin
            j_cnt <= j_cnt + 3'd1;
          end
        end else begin
          if (j_cnt == last_idx) begin
            phase_l <= 1'b0;
            i_cnt   <= i_cnt + 3'd1;
            j_cnt   <= i_cnt + 3'd1;
          end else begin
            j_cnt <= j_cnt + 3'd1;
          end
        end
      end
      dlu_pkg::S_DIV: begin
        rem  <= r2_ge ? DW'(r2 - {1'b0, dmd}) : r2[DW-1:0];
        dsh  <= {dsh[70:0], 1'b0};
        dcnt <= dcnt + 7'd1;
        if (!dbig) begin
          quo  <= q_step;
          dbig <= q_step[49];
        end
      end
      dlu_pkg::S_DIV_END: begin
        if (j_cnt == last_idx) begin
          phase_l <= 1'b0;
          i_cnt   <= i_cnt + 3'd1;
          j_cnt   <= i_cnt + 3'd1;
        end else begin
          j_cnt <= j_cnt + 3'd1;
        end
      end
      dlu_pkg::S_OUT: begin
        if (m_tready) begin
          if (oj == last_idx) begin
            oj <= '0;
            oi <= oi + 3'd1;
          end else begin
            oj <= oj + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  `DLU_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "input taken while results pending")
  `DLU_ASSERT_NEXT(a_load_start, in_xfer && ld_done && !cfg_we, state == dlu_pkg::S_ACC_RD,
    "full matrix did not start decomposition")
  `DLU_ASSERT_NEXT(a_run_end, out_xfer && m_tlast, state == dlu_pkg::S_LOAD,
    "last result did not return to loading")
  `DLU_ASSERT_NEXT(a_cfg_restart, cfg_we, ld_row == '0 && ld_col == '0 && !sing,
    "size write did not restart the load")

endmodule

`default_nettype wire
